### src/dll_pkg.sv
// Package: shared constants, command codes and controller types for the linked-list unit.
`timescale 1ns / 1ps

package dll_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned CMD_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_CLEAR      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_INS_FIRST  = 5'd1;
  localparam logic [CMD_W-1:0] CMD_INS_LAST   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_GO_FIRST   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_GO_LAST    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_RD_FIRST   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_RD_LAST    = 5'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST  = 5'd7;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST   = 5'd8;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 5'd10;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 5'd11;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 5'd12;
  localparam logic [CMD_W-1:0] CMD_RD_ACTIVE  = 5'd13;
  localparam logic [CMD_W-1:0] CMD_WR_ACTIVE  = 5'd14;
  localparam logic [CMD_W-1:0] CMD_STEP_NEXT  = 5'd15;
  localparam logic [CMD_W-1:0] CMD_STEP_PREV  = 5'd16;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 5'd17;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_RESP
  } state_t;

  typedef struct packed {
    logic take;
    logic rd0;
    logic rd1;
    logic rd2;
    logic wr0;
    logic wr1;
    logic load;
  } ctrl_t;

endpackage

### src/dll_ctrl.sv
// Controller: sequences each command through read, write and response phases.
`timescale 1ns / 1ps

module dll_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output dll_pkg::ctrl_t ctrl
);

  dll_pkg::state_t state, state_next;
  logic            m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dll_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl          = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      dll_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.take  = 1'b1;
          state_next = dll_pkg::S_RD0;
        end
      end
      dll_pkg::S_RD0: begin
        ctrl.rd0   = 1'b1;
        state_next = dll_pkg::S_RD1;
      end
      dll_pkg::S_RD1: begin
        ctrl.rd1   = 1'b1;
        state_next = dll_pkg::S_RD2;
      end
      dll_pkg::S_RD2: begin
        ctrl.rd2   = 1'b1;
        state_next = dll_pkg::S_WR0;
      end
      dll_pkg::S_WR0: begin
        ctrl.wr0   = 1'b1;
        state_next = dll_pkg::S_WR1;
      end
      dll_pkg::S_WR1: begin
        ctrl.wr1   = 1'b1;
        state_next = dll_pkg::S_RESP;
      end
      dll_pkg::S_RESP: begin
        // wait for the output register to drain
        if (!m_tvalid || m_tready) begin
          ctrl.load     = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = dll_pkg::S_IDLE;
        end
      end
      default: state_next = dll_pkg::S_IDLE;
    endcase
  end

endmodule

### src/dll_dp.sv
// Datapath: node memories, list pointers, link updates and the result register.
`timescale 1ns / 1ps

module dll_dp #(
  parameter int unsigned CAPACITY = dll_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dll_pkg::ctrl_t                ctrl,
  input  logic [dll_pkg::CMD_W-1:0]     cmd_in,
  input  logic [dll_pkg::DATA_W-1:0]    din_in,
  output logic [dll_pkg::DATA_W-1:0]    dout,
  output logic [dll_pkg::STATUS_W-1:0]  status,
  output logic                          cursor_set
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [dll_pkg::DATA_W-1:0] val_mem  [CAPACITY];
  logic [IW-1:0]              prev_mem [CAPACITY];
  logic [IW-1:0]              next_mem [CAPACITY];
  logic [CAPACITY-1:0]        next_vld;

  logic [dll_pkg::CMD_W-1:0]  cmd;
  logic [dll_pkg::DATA_W-1:0] din;
  logic [IW-1:0] head, tail, cur, free;
  logic [IW-1:0] head_next, tail_next, cur_next, free_next;
  logic [IW-1:0] a_n, a_p, b_n, b_p;
  logic [dll_pkg::DATA_W-1:0] a_v;
  logic [dll_pkg::DATA_W-1:0]   res_dout, res_dout_next;
  logic [dll_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [IW-1:0]              ra, ra_q;
  logic [dll_pkg::DATA_W-1:0] rv_q;
  logic [IW-1:0]              rp_q, rn_q, next_out;
  logic                       nv_q;

  logic                       we_v, we_p, we_n;
  logic [IW-1:0]              wa_v, wa_p, wa_n, wd_p, wd_n;

  logic empty, single, full, nocur;

  assign empty  = (head == NIL);
  assign single = (head == tail);
  assign full   = (free == NIL);
  assign nocur  = (cur == NIL);

  // next links never written read as the reset chain, entry i to i plus one
  assign next_out = nv_q ? rn_q : ra_q + IW'(1);

  // read address: first read in RD0, dependent read in RD1
  always_comb begin
    ra = '0;
    if (ctrl.rd0) begin
      unique case (cmd)
        dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST,
        dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_INS_BEFORE: ra = free;
        dll_pkg::CMD_RD_FIRST, dll_pkg::CMD_DEL_FIRST:   ra = head;
        dll_pkg::CMD_RD_LAST, dll_pkg::CMD_DEL_LAST:     ra = tail;
        default:                                         ra = cur;
      endcase
    end else if (ctrl.rd1) begin
      unique case (cmd)
        dll_pkg::CMD_DEL_AFTER:  ra = next_out;
        dll_pkg::CMD_DEL_BEFORE: ra = rp_q;
        default:                 ra = cur;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rv_q <= val_mem[ra[AW-1:0]];
    rp_q <= prev_mem[ra[AW-1:0]];
    rn_q <= next_mem[ra[AW-1:0]];
    nv_q <= next_vld[ra[AW-1:0]];
    ra_q <= ra;
  end

  // memory writes for the two write phases
  always_comb begin
    we_v = 1'b0; wa_v = free;
    we_p = 1'b0; wa_p = '0; wd_p = '0;
    we_n = 1'b0; wa_n = '0; wd_n = '0;
    if (ctrl.wr0) begin
      unique case (cmd)
        dll_pkg::CMD_CLEAR: begin
          we_n = !empty; wa_n = tail; wd_n = free;
        end
        dll_pkg::CMD_INS_FIRST: begin
          we_v = !full;
          we_p = !full; wa_p = free; wd_p = NIL;
          we_n = !full; wa_n = free; wd_n = head;
        end
        dll_pkg::CMD_INS_LAST: begin
          we_v = !full;
          we_n = !full; wa_n = free; wd_n = NIL;
          we_p = !full; wa_p = free; wd_p = tail;
        end
        dll_pkg::CMD_DEL_FIRST: begin
          we_p = !empty && !single; wa_p = a_n; wd_p = NIL;
        end
        dll_pkg::CMD_DEL_LAST: begin
          we_n = !empty && !single; wa_n = a_p; wd_n = NIL;
        end
        dll_pkg::CMD_DEL_AFTER: begin
          we_n = !nocur && (cur != tail); wa_n = cur; wd_n = b_n;
        end
        dll_pkg::CMD_DEL_BEFORE: begin
          we_p = !nocur && (cur != head); wa_p = cur; wd_p = b_p;
          we_n = !nocur && (cur != head) && (b_p != NIL); wa_n = b_p; wd_n = cur;
        end
        dll_pkg::CMD_INS_AFTER: begin
          we_v = !nocur && !full;
          we_p = !nocur && !full; wa_p = free; wd_p = cur;
          we_n = !nocur && !full; wa_n = free; wd_n = b_n;
        end
        dll_pkg::CMD_INS_BEFORE: begin
          we_v = !nocur && !full;
          we_n = !nocur && !full; wa_n = free; wd_n = cur;
          we_p = !nocur && !full; wa_p = free; wd_p = b_p;
        end
        dll_pkg::CMD_WR_ACTIVE: begin
          we_v = !nocur; wa_v = cur;
        end
        default: ;
      endcase
    end else if (ctrl.wr1) begin
      unique case (cmd)
        dll_pkg::CMD_INS_FIRST: begin
          we_p = !full && !empty; wa_p = head; wd_p = free;
        end
        dll_pkg::CMD_INS_LAST: begin
          we_n = !full && (tail != NIL); wa_n = tail; wd_n = free;
        end
        dll_pkg::CMD_DEL_FIRST: begin
          we_n = !empty; wa_n = head; wd_n = free;
        end
        dll_pkg::CMD_DEL_LAST: begin
          we_n = !empty; wa_n = tail; wd_n = free;
        end
        dll_pkg::CMD_DEL_AFTER: begin
          we_n = !nocur && (cur != tail); wa_n = a_n; wd_n = free;
          we_p = !nocur && (cur != tail) && (b_n != NIL); wa_p = b_n; wd_p = cur;
        end
        dll_pkg::CMD_DEL_BEFORE: begin
          we_n = !nocur && (cur != head); wa_n = a_p; wd_n = free;
        end
        dll_pkg::CMD_INS_AFTER: begin
          we_p = !nocur && !full && (cur != tail); wa_p = b_n; wd_p = free;
          we_n = !nocur && !full; wa_n = cur; wd_n = free;
        end
        dll_pkg::CMD_INS_BEFORE: begin
          we_n = !nocur && !full && (cur != head); wa_n = b_p; wd_n = free;
          we_p = !nocur && !full; wa_p = cur; wd_p = free;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_v && wa_v != NIL) val_mem[wa_v[AW-1:0]] <= din;
    if (we_p && wa_p != NIL) prev_mem[wa_p[AW-1:0]] <= wd_p;
    if (we_n && wa_n != NIL) next_mem[wa_n[AW-1:0]] <= wd_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
    end else if (we_n && wa_n != NIL) begin
      next_vld[wa_n[AW-1:0]] <= 1'b1;
    end
  end

  // pointer updates and result, applied at the end of the last write phase
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    cur_next        = cur;
    free_next       = free;
    res_dout_next   = '0;
    res_status_next = dll_pkg::ST_OK;
    unique case (cmd)
      dll_pkg::CMD_CLEAR: begin
        if (!empty) free_next = head;
        head_next = NIL; tail_next = NIL; cur_next = NIL;
      end
      dll_pkg::CMD_INS_FIRST: begin
        if (full) res_status_next = dll_pkg::ST_FULL;
        else begin
          free_next = a_n;
          if (empty) tail_next = free;
          head_next = free;
        end
      end
      dll_pkg::CMD_INS_LAST: begin
        if (full) res_status_next = dll_pkg::ST_FULL;
        else begin
          free_next = a_n;
          if (tail == NIL) head_next = free;
          tail_next = free;
        end
      end
      dll_pkg::CMD_GO_FIRST: cur_next = head;
      dll_pkg::CMD_GO_LAST:  cur_next = tail;
      dll_pkg::CMD_RD_FIRST: begin
        if (empty) res_status_next = dll_pkg::ST_EMPTY;
        else res_dout_next = a_v;
      end
      dll_pkg::CMD_RD_LAST: begin
        if (tail == NIL) res_status_next = dll_pkg::ST_EMPTY;
        else res_dout_next = a_v;
      end
      dll_pkg::CMD_RD_ACTIVE: begin
        if (nocur) res_status_next = dll_pkg::ST_EMPTY;
        else res_dout_next = a_v;
      end
      dll_pkg::CMD_DEL_FIRST: begin
        if (!empty) begin
          if (cur == head) cur_next = NIL;
          if (single) begin
            head_next = NIL; tail_next = NIL;
          end else head_next = a_n;
          free_next = head;
        end
      end
      dll_pkg::CMD_DEL_LAST: begin
        if (!empty) begin
          if (cur == tail) cur_next = NIL;
          if (single) begin
            head_next = NIL; tail_next = NIL;
          end else tail_next = a_p;
          free_next = tail;
        end
      end
      dll_pkg::CMD_DEL_AFTER: begin
        if (!nocur && cur != tail) begin
          if (b_n == NIL) tail_next = cur;
          free_next = a_n;
        end
      end
      dll_pkg::CMD_DEL_BEFORE: begin
        if (!nocur && cur != head) begin
          if (b_p == NIL) head_next = cur;
          free_next = a_p;
        end
      end
      dll_pkg::CMD_INS_AFTER: begin
        if (!nocur) begin
          if (full) res_status_next = dll_pkg::ST_FULL;
          else begin
            free_next = a_n;
            if (cur == tail) tail_next = free;
          end
        end
      end
      dll_pkg::CMD_INS_BEFORE: begin
        if (!nocur) begin
          if (full) res_status_next = dll_pkg::ST_FULL;
          else begin
            free_next = a_n;
            if (cur == head) head_next = free;
          end
        end
      end
      dll_pkg::CMD_STEP_NEXT: if (!nocur) cur_next = a_n;
      dll_pkg::CMD_STEP_PREV: if (!nocur) cur_next = a_p;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NIL;
      tail <= NIL;
      cur  <= NIL;
      free <= '0;
    end else if (ctrl.wr1) begin
      head <= head_next;
      tail <= tail_next;
      cur  <= cur_next;
      free <= free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cmd <= cmd_in;
      din <= din_in;
    end
    if (ctrl.rd1) begin
      a_n <= next_out;
      a_p <= rp_q;
      a_v <= rv_q;
    end
    if (ctrl.rd2) begin
      b_n <= next_out;
      b_p <= rp_q;
    end
    if (ctrl.wr1) begin
      res_dout   <= res_dout_next;
      res_status <= res_status_next;
    end
    if (ctrl.load) begin
      dout       <= res_dout;
      status     <= res_status;
      cursor_set <= (cur != NIL);
    end
  end

endmodule

### src/doubly_linked_list_with_cursor_unit.sv
// Top level: doubly linked list with cursor over a pooled node memory.
`timescale 1ns / 1ps

// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   command[4:0], data_in[36:5], zero pad to 40 bits
// m_axis    out  data_out[31:0], status[33:32], cursor_set[34], zero pad
//
// Every command passes from acceptance to a loaded result through a first
// node read, a dependent read, a capture phase, two write phases and the result
// load. The single read port of the node memories and the link writes set that
// sequence. The next command is accepted in the cycle after the load; a full
// output register holds the controller in its load phase until the result is
// taken. The next command is accepted while the previous result waits in the
// output register. Reset is synchronous and clears the list to empty with the
// free chain in index order; no clearing pass is needed.

module doubly_linked_list_with_cursor_unit #(
  parameter int unsigned CAPACITY = dll_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command[4:0], data_in[36:5]
  input  logic [dll_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // data_out[31:0], status[33:32], cursor_set[34]
  output logic [dll_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  dll_pkg::ctrl_t                ctrl;
  logic [dll_pkg::DATA_W-1:0]    dout;
  logic [dll_pkg::STATUS_W-1:0]  status;
  logic                          cursor_set;

  // sequence each transaction through its phases
  dll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .ctrl     (ctrl)
  );

  // node memories, pointers and result register
  dll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cmd_in     (s_axis_tdata[4:0]),
    .din_in     (s_axis_tdata[36:5]),
    .dout       (dout),
    .status     (status),
    .cursor_set (cursor_set)
  );

  // pack the result, pad upper bits with zeros
  assign m_axis_tdata = {5'd0, cursor_set, status, dout};

endmodule
